// File: rtl/core/tzr_pkg.sv
// tzr_pkg: shared types and constants of the triangle rasterizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tzr_pkg;
  localparam logic signed [15:0] DepthReset = 16'sh8000;
  localparam logic [16:0] CountMax = 17'h1ffff;
  localparam logic OpDraw = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef enum logic [11:0] {
    StIdle   = 12'b000000000001,
    StClear  = 12'b000000000010,
    StSetup  = 12'b000000000100,
    StArea   = 12'b000000001000,
    StBox    = 12'b000000010000,
    StEdge   = 12'b000000100000,
    StNum    = 12'b000001000000,
    StDiv    = 12'b000010000000,
    StRdWait = 12'b000100000000,
    StTest   = 12'b001000000000,
    StRead   = 12'b010000000000,
    StDone   = 12'b100000000000
  } state_e;
endpackage
`default_nettype wire

// File: rtl/core/tzr_ram.sv
// tzr_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module tzr_ram #(
  parameter int Width = 16,
  parameter int Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem [Depth];
  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// File: rtl/core/triangle_zbuffer_rasterizer.sv
// triangle_zbuffer_rasterizer: bounding-box triangle fill with depth buffer
// depends on tzr_pkg and tzr_ram
//
// channel   dir  signals                         handshake
// command   in   start_i, opcode_i, vertex_*_i   start_i & !busy_o
// result    out  done_o, pixels_written_o ...    done_o, one cycle, no stall
//
// after reset a clearing pass over all FRAME_WIDTH*FRAME_HEIGHT pixels runs with busy_o high
// draw: setup (StSetup, StArea, StBox), then per box pixel the edge test (StEdge) and, if inside,
// StNum, StDiv, StRdWait, StTest (one shared multiplier, a 47-bit restoring divider one bit a
// cycle), then StDone with the result strobe; zero area or no box left: StBox goes to StDone
// read: StRead then StDone, the result strobe in StDone, the last busy state
`timescale 1ns / 1ps
`default_nettype none
module triangle_zbuffer_rasterizer #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               opcode_i,
  input  wire logic signed [11:0] vertex_x0_i,
  input  wire logic signed [11:0] vertex_y0_i,
  input  wire logic signed [15:0] vertex_z0_i,
  input  wire logic signed [11:0] vertex_x1_i,
  input  wire logic signed [11:0] vertex_y1_i,
  input  wire logic signed [15:0] vertex_z1_i,
  input  wire logic signed [11:0] vertex_x2_i,
  input  wire logic signed [11:0] vertex_y2_i,
  input  wire logic signed [15:0] vertex_z2_i,
  input  wire logic        [23:0] fill_color_i,
  input  wire logic        [15:0] read_index_i,
  output logic                    done_o,
  output logic             [16:0] pixels_written_o,
  output logic             [23:0] pixel_color_o,
  output logic signed      [15:0] pixel_depth_o
);
  localparam int Pixels = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AddrW  = $clog2(Pixels);

  tzr_pkg::state_e state_q, state_d;

  logic signed [12:0] ex1_q, ey1_q, ex2_q, ey2_q; // x1-x0 etc.
  logic signed [11:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic signed [15:0] z0_q, z1_q, z2_q;
  logic [23:0] color_q;
  logic [15:0] ridx_q;
  logic op_q;
  logic signed [12:0] px_q, py_q, lx_q, hx_q, hy_q, ly_q;
  logic signed [26:0] uz_q, ux_q, uy_q;
  logic signed [47:0] num_q;
  logic [2:0] step_q;
  logic [16:0] count_q;
  logic [AddrW:0] clr_q;
  // divider
  logic [46:0] dnum_q, drem_q;
  logic [5:0] dbit_q;
  logic dneg_q;
  logic signed [16:0] depth_q;

  // shared multiplier 27x17 signed
  logic signed [26:0] ma;
  logic signed [16:0] mb;
  logic signed [43:0] mp;
  assign mp = ma * mb;

  // edge product helpers
  logic signed [12:0] dx0, dy0;
  assign dx0 = 13'(x0_q) - px_q;
  assign dy0 = 13'(y0_q) - py_q;

  always_comb begin
    ma = '0; mb = '0;
    case (step_q)
      3'd0: begin ma = 27'(ex2_q); mb = 17'(ey1_q); end
      3'd1: begin ma = 27'(ex1_q); mb = 17'(ey2_q); end
      3'd2: begin ma = 27'(ex1_q); mb = 17'(dy0); end
      3'd3: begin ma = 27'(dx0);  mb = 17'(ey1_q); end
      3'd4: begin ma = 27'(dx0);  mb = 17'(ey2_q); end
      3'd5: begin ma = 27'(ex2_q); mb = 17'(dy0); end
      3'd6: begin ma = uz_q - ux_q - uy_q; mb = 17'(z0_q); end
      3'd7: begin ma = uy_q; mb = 17'(z1_q); end
      default: ;
    endcase
    // last numerator term
    if (state_q == tzr_pkg::StNum && step_q == 3'd1) begin
      ma = ux_q; mb = 17'(z2_q);
    end
  end

  logic signed [26:0] uw;
  assign uw = uz_q - ux_q - uy_q;
  function automatic logic side(logic signed [26:0] a, logic signed [26:0] z);
    side = (a == 0) || ((a > 0) == (z > 0));
  endfunction
  logic inside_w;
  assign inside_w = side(ux_q, uz_q) && side(uy_q, uz_q) && side(uw, uz_q);

  // memories
  logic we;
  logic [AddrW-1:0] addr;
  logic [15:0] dwdata, drd;
  logic [23:0] cwdata, crd;
  logic [31:0] pix_addr;
  assign pix_addr = 32'(py_q) * 32'(FRAME_WIDTH) + 32'(px_q);

  tzr_ram #(.Width(16), .Depth(Pixels)) u_depth (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(dwdata), .rdata_o(drd));
  tzr_ram #(.Width(24), .Depth(Pixels)) u_color (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(cwdata), .rdata_o(crd));

  always_comb begin
    we = 1'b0; dwdata = 16'(depth_q); cwdata = color_q;
    addr = AddrW'(pix_addr);
    if (state_q == tzr_pkg::StClear) begin
      we = 1'b1; addr = clr_q[AddrW-1:0];
      dwdata = tzr_pkg::DepthReset; cwdata = '0;
    end else if (state_q == tzr_pkg::StTest) begin
      we = $signed(depth_q) > $signed({drd[15], drd});
    end else if (state_q == tzr_pkg::StIdle || state_q == tzr_pkg::StRead ||
                 state_q == tzr_pkg::StDone) begin
      addr = AddrW'(ridx_q);
    end
  end

  logic [47:0] abs_num;
  logic [26:0] abs_uz;
  assign abs_num = num_q[47] ? 48'(-num_q) : 48'(num_q);
  assign abs_uz  = uz_q[26] ? 27'(-uz_q) : 27'(uz_q);
  logic [47:0] trial;
  assign trial = {drem_q, dnum_q[46]} - 48'(abs_uz);

  logic last_px;
  assign last_px = (py_q == hy_q) && (px_q == hx_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      tzr_pkg::StIdle:   if (start_i) state_d = (opcode_i == tzr_pkg::OpRead) ?
                           tzr_pkg::StRead : tzr_pkg::StSetup;
      tzr_pkg::StClear:  if (clr_q == (AddrW+1)'(Pixels-1)) state_d = tzr_pkg::StIdle;
      tzr_pkg::StSetup:  state_d = tzr_pkg::StArea;
      tzr_pkg::StArea:   if (step_q == 3'd1) state_d = tzr_pkg::StBox;
      tzr_pkg::StBox:    state_d = (uz_q == 0 || lx_q > hx_q || ly_q > hy_q) ?
                           tzr_pkg::StDone : tzr_pkg::StEdge;
      tzr_pkg::StEdge:   if (step_q == 3'd6) state_d = inside_w ? tzr_pkg::StNum :
                           (last_px ? tzr_pkg::StDone : tzr_pkg::StEdge);
      tzr_pkg::StNum:    if (step_q == 3'd1) state_d = tzr_pkg::StDiv;
      tzr_pkg::StDiv:    if (dbit_q == 6'd47) state_d = tzr_pkg::StRdWait;
      tzr_pkg::StRdWait: state_d = tzr_pkg::StTest;
      tzr_pkg::StTest:   state_d = last_px ? tzr_pkg::StDone : tzr_pkg::StEdge;
      tzr_pkg::StRead:   state_d = tzr_pkg::StDone;
      tzr_pkg::StDone:   state_d = tzr_pkg::StIdle;
      default:           state_d = tzr_pkg::StIdle;
    endcase
  end

  function automatic logic signed [11:0] mn(logic signed [11:0] a, logic signed [11:0] b);
    mn = (a < b) ? a : b;
  endfunction
  function automatic logic signed [11:0] mx(logic signed [11:0] a, logic signed [11:0] b);
    mx = (a > b) ? a : b;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tzr_pkg::StClear;
      clr_q <= '0; step_q <= '0; count_q <= '0; done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o <= 1'b0;
      case (state_q)
        tzr_pkg::StClear: clr_q <= clr_q + 1'b1;
        tzr_pkg::StIdle: if (start_i) begin
          op_q <= opcode_i; ridx_q <= read_index_i; color_q <= fill_color_i;
          x0_q <= vertex_x0_i; y0_q <= vertex_y0_i; z0_q <= vertex_z0_i;
          x1_q <= vertex_x1_i; y1_q <= vertex_y1_i; z1_q <= vertex_z1_i;
          x2_q <= vertex_x2_i; y2_q <= vertex_y2_i; z2_q <= vertex_z2_i;
          count_q <= '0; step_q <= '0;
        end
        tzr_pkg::StSetup: begin
          ex1_q <= 13'(x1_q) - 13'(x0_q); ey1_q <= 13'(y1_q) - 13'(y0_q);
          ex2_q <= 13'(x2_q) - 13'(x0_q); ey2_q <= 13'(y2_q) - 13'(y0_q);
          lx_q <= 13'(mn(mn(x0_q, x1_q), x2_q)); hx_q <= 13'(mx(mx(x0_q, x1_q), x2_q));
          ly_q <= 13'(mn(mn(y0_q, y1_q), y2_q)); hy_q <= 13'(mx(mx(y0_q, y1_q), y2_q));
        end
        tzr_pkg::StArea: begin
          if (step_q == 3'd0) begin
            uz_q <= 27'(mp); step_q <= 3'd1;
          end else begin
            uz_q <= uz_q - 27'(mp); step_q <= 3'd2;
          end
          if (lx_q < 0) lx_q <= '0;
          if (ly_q < 0) ly_q <= '0;
          if (hx_q > 13'(FRAME_WIDTH - 1)) hx_q <= 13'(FRAME_WIDTH - 1);
          if (hy_q > 13'(FRAME_HEIGHT - 1)) hy_q <= 13'(FRAME_HEIGHT - 1);
        end
        tzr_pkg::StBox: begin
          px_q <= lx_q; py_q <= ly_q; step_q <= 3'd2;
          if (state_d == tzr_pkg::StDone) done_o <= 1'b1;
        end
        tzr_pkg::StEdge: begin
          case (step_q)
            3'd2: begin ux_q <= 27'(mp); step_q <= 3'd3; end
            3'd3: begin ux_q <= ux_q - 27'(mp); step_q <= 3'd4; end
            3'd4: begin uy_q <= 27'(mp); step_q <= 3'd5; end
            3'd5: begin uy_q <= uy_q - 27'(mp); step_q <= 3'd6; end
            default: begin
              if (inside_w) begin
                num_q <= 48'(mp); step_q <= 3'd7;
              end else begin
                step_q <= 3'd2;
                if (py_q == hy_q) begin py_q <= ly_q; px_q <= px_q + 1'b1; end
                else py_q <= py_q + 1'b1;
                if (last_px) done_o <= 1'b1;
              end
            end
          endcase
        end
        tzr_pkg::StNum: begin
          if (step_q == 3'd7) begin
            num_q <= num_q + 48'(mp); step_q <= 3'd1;
          end else begin
            num_q <= num_q + 48'(mp);
            step_q <= 3'd2;
          end
          dbit_q <= '0; drem_q <= '0;
        end
        tzr_pkg::StDiv: begin
          if (dbit_q == 6'd0) begin
            dnum_q <= abs_num[46:0]; drem_q <= '0;
            dneg_q <= num_q[47] ^ uz_q[26];
            dbit_q <= 6'd1;
          end else begin
            if (!trial[47]) drem_q <= trial[46:0];
            else drem_q <= {drem_q[45:0], dnum_q[46]};
            dnum_q <= {dnum_q[45:0], !trial[47]};
            dbit_q <= dbit_q + 1'b1;
          end
        end
        tzr_pkg::StRdWait: begin
          // quotient is dnum_q; saturate to 16 bits
          if (dneg_q) depth_q <= (dnum_q > 47'd32768) ? -17'sd32768 : 17'(-$signed({1'b0, dnum_q}));
          else depth_q <= (dnum_q > 47'd32767) ? 17'sd32767 : 17'(dnum_q);
        end
        tzr_pkg::StTest: begin
          if (we && count_q != tzr_pkg::CountMax) count_q <= count_q + 1'b1;
          step_q <= 3'd2;
          if (py_q == hy_q) begin py_q <= ly_q; px_q <= px_q + 1'b1; end
          else py_q <= py_q + 1'b1;
          if (last_px) done_o <= 1'b1;
        end
        tzr_pkg::StRead: done_o <= 1'b1;
        default: ;
      endcase
    end
  end

  assign busy_o = state_q != tzr_pkg::StIdle;
  // result word
  logic rd_ok;
  assign rd_ok = 32'(ridx_q) < 32'(Pixels);
  always_comb begin
    pixels_written_o = '0; pixel_color_o = '0; pixel_depth_o = '0;
    if (op_q == tzr_pkg::OpRead) begin
      if (rd_ok) begin pixel_color_o = crd; pixel_depth_o = drd; end
    end else begin
      pixels_written_o = count_q;
    end
  end

  // assertions
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result outside a command");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result strobe");
endmodule
`default_nettype wire
